@@ hw/rtl/ddo_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the differential-drive odometry unit.
// Used by ddo_serial_mul, differential_drive_odometry_unit, pose_checker and the testbench; no dependencies.
package ddo_pkg;

    localparam int CNT_W  = 32;    // encoder count width
    localparam int STEP_W = 32;    // per-pulse travel register width
    localparam int GAIN_W = 40;    // heading gain register width
    localparam int ACC_W  = 48;    // position and distance width
    localparam int HEAD_W = 32;    // heading width
    localparam int CFG_W  = 40;    // widest configuration register
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_STEP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_STEP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADING_GAIN = 2'd2;

    // CORDIC rotation engine, Q30 with guard bits
    localparam int CORDIC_STEPS = 28;
    localparam int CORDIC_IDX_W = 5;
    localparam int CORDIC_W     = 33;
    localparam logic [CORDIC_W-1:0] CORDIC_K = 33'd652032874;

    typedef struct packed {
        logic load;    // capture operands, restart the bit counter
        logic run;     // consume one multiplier bit
    } t_mul_ctrl;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIST = 5'b00010,
        S_MID  = 5'b00100,
        S_MUL  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [CORDIC_IDX_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h2000_0000;
            5'd1:  v = 32'h12E4_051E;
            5'd2:  v = 32'h09FB_385B;
            5'd3:  v = 32'h0511_11D4;
            5'd4:  v = 32'h028B_0D43;
            5'd5:  v = 32'h0145_D7E1;
            5'd6:  v = 32'h00A2_F61E;
            5'd7:  v = 32'h0051_7C55;
            5'd8:  v = 32'h0028_BE53;
            5'd9:  v = 32'h0014_5F2F;
            5'd10: v = 32'h000A_2F98;
            5'd11: v = 32'h0005_17CC;
            5'd12: v = 32'h0002_8BE6;
            5'd13: v = 32'h0001_45F3;
            5'd14: v = 32'h0000_A2FA;
            5'd15: v = 32'h0000_517D;
            5'd16: v = 32'h0000_28BE;
            5'd17: v = 32'h0000_145F;
            5'd18: v = 32'h0000_0A30;
            5'd19: v = 32'h0000_0518;
            5'd20: v = 32'h0000_028C;
            5'd21: v = 32'h0000_0146;
            5'd22: v = 32'h0000_00A3;
            5'd23: v = 32'h0000_0051;
            5'd24: v = 32'h0000_0029;
            5'd25: v = 32'h0000_0014;
            5'd26: v = 32'h0000_000A;
            5'd27: v = 32'h0000_0005;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

    // clamp a 50-bit two's complement value to the 48-bit range
    function automatic logic [ACC_W-1:0] sat48(input logic [ACC_W+1:0] v);
        logic [ACC_W-1:0] r;
        if (!v[ACC_W+1] && (v[ACC_W:ACC_W-1] != 2'b00)) begin
            r = {1'b0, {(ACC_W-1){1'b1}}};
        end else if (v[ACC_W+1] && (v[ACC_W:ACC_W-1] != 2'b11)) begin
            r = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            r = v[ACC_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/differential_drive_odometry_unit.sv @@
`timescale 1ns / 1ps
// Differential-drive wheel odometry integrator, top level.
// Depends on ddo_pkg and ddo_serial_mul.
//
// Usage:
//   Write left_step, right_step and heading_gain through i_cfg_we / i_cfg_idx /
//   i_cfg_data while the unit is idle; writes take effect at once.
//   Input items (i_left_count, i_right_count, i_new_interval) enter on
//   i_valid / o_ready; one result item (pose, heading, distance, moved) leaves
//   on o_valid / i_ready for every input item.
//   An item that moves goes through a bit-serial wheel-distance multiply
//   (CORDIC running alongside), a step for mean and difference, a bit-serial
//   heading-gain multiply and an accumulate. The very first item after reset
//   only sets the count reference and goes straight to the final step,
//   skipping the arithmetic. A new item is accepted only after the last one
//   has left its final step; o_ready is high only while idle.
//   Reset clears configuration, count reference, pose and distance.
//   The output register holds a result until taken; the next item is accepted
//   and worked on meanwhile, and waits in its final step while i_ready is low.
module differential_drive_odometry_unit #(
    parameter int TRIG_FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ddo_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ddo_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [ddo_pkg::CNT_W-1:0]          i_left_count,
    input  logic [ddo_pkg::CNT_W-1:0]          i_right_count,
    input  logic                               i_new_interval,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [ddo_pkg::ACC_W-1:0]   o_pos_x,
    output logic signed [ddo_pkg::ACC_W-1:0]   o_pos_z,
    output logic [ddo_pkg::HEAD_W-1:0]         o_heading,
    output logic signed [ddo_pkg::ACC_W-1:0]   o_travelled,
    output logic                               o_moved
);
    import ddo_pkg::*;

    localparam int TRIG_W  = TRIG_FRAC_BITS + 3;
    localparam int DIST_PW = CNT_W + STEP_W + 1;
    localparam int DIFF_W  = ACC_W + 1;
    localparam int GAIN_PW = DIFF_W + GAIN_W + 1;
    localparam int TRIG_PW = ACC_W + TRIG_W;
    localparam logic [CORDIC_W-1:0] ROUND_HALF = CORDIC_W'(1) << (29 - TRIG_FRAC_BITS);
    localparam logic [CORDIC_IDX_W-1:0] ITER_END = CORDIC_IDX_W'(CORDIC_STEPS);

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    // configuration
    logic [STEP_W-1:0] r_left_step;
    logic [STEP_W-1:0] r_right_step;
    logic [GAIN_W-1:0] r_heading_gain;

    // integrator state
    logic [CNT_W-1:0]  r_last_left;
    logic [CNT_W-1:0]  r_last_right;
    logic              r_have_ref;
    logic [ACC_W-1:0]  r_acc_x;
    logic [ACC_W-1:0]  r_acc_z;
    logic [ACC_W-1:0]  r_acc_dist;
    logic [HEAD_W-1:0] r_acc_heading;
    logic              r_moved;

    t_state r_state;
    t_state n_state;

    // CORDIC
    logic [CORDIC_W-1:0]     r_cx;
    logic [CORDIC_W-1:0]     r_cy;
    logic [31:0]             r_cz;
    logic [CORDIC_IDX_W-1:0] r_iter;
    logic [1:0]              r_quad;

    // output register
    logic              r_out_valid;
    logic [ACC_W-1:0]  r_out_x;
    logic [ACC_W-1:0]  r_out_z;
    logic [HEAD_W-1:0] r_out_heading;
    logic [ACC_W-1:0]  r_out_dist;
    logic              r_out_moved;

    logic accept;
    logic emit;

    logic [CNT_W-1:0]  d_left;
    logic [CNT_W-1:0]  d_right;
    logic [HEAD_W-1:0] head_eff;
    logic [HEAD_W-1:0] head_rot;
    logic              cordic_run;
    logic              cordic_done;
    logic [CORDIC_W-1:0] shx;
    logic [CORDIC_W-1:0] shy;
    logic [CORDIC_W-1:0] rnd_c;
    logic [CORDIC_W-1:0] rnd_s;
    logic [TRIG_W-1:0] c_raw;
    logic [TRIG_W-1:0] s_raw;
    logic [TRIG_W-1:0] cos_q;
    logic [TRIG_W-1:0] sin_q;

    logic [ACC_W-1:0]  dist_l;
    logic [ACC_W-1:0]  dist_r;
    logic [DIFF_W-1:0] wsum;
    logic [ACC_W-1:0]  mean;
    logic [DIFF_W-1:0] diff;

    t_mul_ctrl dist_ctl;
    t_mul_ctrl mid_ctl;
    logic [DIST_PW-1:0] p_left;
    logic [DIST_PW-1:0] p_right;
    logic [GAIN_PW-1:0] p_turn;
    logic [TRIG_PW-1:0] p_sin;
    logic [TRIG_PW-1:0] p_cos;
    logic done_left;
    logic done_right;
    logic done_turn;
    logic done_sin;
    logic done_cos;

    logic [ACC_W:0]    dx_prod;
    logic [ACC_W:0]    dz_prod;
    logic [ACC_W-1:0]  n_acc_x;
    logic [ACC_W-1:0]  n_acc_z;
    logic [ACC_W-1:0]  n_acc_dist;
    logic [HEAD_W-1:0] n_acc_heading;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign emit    = (r_state == S_DONE) && (!r_out_valid || i_ready);

    // wrapped count differences and effective old heading
    assign d_left   = i_left_count - r_last_left;
    assign d_right  = i_right_count - r_last_right;
    assign head_eff = i_new_interval ? '0 : r_acc_heading;
    assign head_rot = head_eff + 32'h2000_0000;

    assign cordic_done = (r_iter == ITER_END);
    assign cordic_run  = (r_state == S_DIST) && !cordic_done;
    assign shx = $signed(r_cy) >>> r_iter;
    assign shy = $signed(r_cx) >>> r_iter;

    // round half up to TRIG_FRAC_BITS and map the quadrant back
    assign rnd_c = r_cx + ROUND_HALF;
    assign rnd_s = r_cy + ROUND_HALF;
    assign c_raw = rnd_c[CORDIC_W-1:30-TRIG_FRAC_BITS];
    assign s_raw = rnd_s[CORDIC_W-1:30-TRIG_FRAC_BITS];

    always_comb begin
        case (r_quad)
            QUAD_0: begin
                cos_q = c_raw;
                sin_q = s_raw;
            end
            QUAD_1: begin
                cos_q = -s_raw;
                sin_q = c_raw;
            end
            QUAD_2: begin
                cos_q = -c_raw;
                sin_q = -s_raw;
            end
            default: begin
                cos_q = s_raw;
                sin_q = -c_raw;
            end
        endcase
    end

    assign dist_l = p_left[CNT_W+STEP_W-1:16];
    assign dist_r = p_right[CNT_W+STEP_W-1:16];
    assign wsum   = {dist_l[ACC_W-1], dist_l} + {dist_r[ACC_W-1], dist_r};
    assign mean   = wsum[DIFF_W-1:1];
    assign diff   = {dist_r[ACC_W-1], dist_r} - {dist_l[ACC_W-1], dist_l};

    assign dist_ctl.load = accept && r_have_ref;
    assign dist_ctl.run  = (r_state == S_DIST);
    assign mid_ctl.load  = (r_state == S_MID);
    assign mid_ctl.run   = (r_state == S_MUL);

    ddo_serial_mul #(.A_W(CNT_W), .B_W(STEP_W + 1)) u_mul_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (dist_ctl),
        .i_a     (d_left),
        .i_b     ({1'b0, r_left_step}),
        .o_p     (p_left),
        .o_done  (done_left)
    );

    ddo_serial_mul #(.A_W(CNT_W), .B_W(STEP_W + 1)) u_mul_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (dist_ctl),
        .i_a     (d_right),
        .i_b     ({1'b0, r_right_step}),
        .o_p     (p_right),
        .o_done  (done_right)
    );

    ddo_serial_mul #(.A_W(DIFF_W), .B_W(GAIN_W + 1)) u_mul_turn (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mid_ctl),
        .i_a     (diff),
        .i_b     ({1'b0, r_heading_gain}),
        .o_p     (p_turn),
        .o_done  (done_turn)
    );

    ddo_serial_mul #(.A_W(ACC_W), .B_W(TRIG_W)) u_mul_sin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mid_ctl),
        .i_a     (mean),
        .i_b     (sin_q),
        .o_p     (p_sin),
        .o_done  (done_sin)
    );

    ddo_serial_mul #(.A_W(ACC_W), .B_W(TRIG_W)) u_mul_cos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mid_ctl),
        .i_a     (mean),
        .i_b     (cos_q),
        .o_p     (p_cos),
        .o_done  (done_cos)
    );

    // floor of product / 2^TRIG_FRAC_BITS, then saturating accumulate
    assign dx_prod = p_sin[TRIG_FRAC_BITS+ACC_W:TRIG_FRAC_BITS];
    assign dz_prod = p_cos[TRIG_FRAC_BITS+ACC_W:TRIG_FRAC_BITS];

    always_comb begin
        n_acc_x       = r_acc_x;
        n_acc_z       = r_acc_z;
        n_acc_dist    = r_acc_dist;
        n_acc_heading = r_acc_heading;
        if (r_moved) begin
            n_acc_x = sat48({{2{r_acc_x[ACC_W-1]}}, r_acc_x} -
                            {dx_prod[ACC_W], dx_prod});
            n_acc_z = sat48({{2{r_acc_z[ACC_W-1]}}, r_acc_z} -
                            {dz_prod[ACC_W], dz_prod});
            n_acc_dist = sat48({{2{r_acc_dist[ACC_W-1]}}, r_acc_dist} +
                               {{2{mean[ACC_W-1]}}, mean});
            n_acc_heading = r_acc_heading + p_turn[63:32];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = r_have_ref ? S_DIST : S_DONE;
                end
            end
            S_DIST: begin
                if (done_left && done_right && cordic_done) begin
                    n_state = S_MID;
                end
            end
            S_MID: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                if (done_turn && done_sin && done_cos) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (emit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_left_step    <= '0;
            r_right_step   <= '0;
            r_heading_gain <= '0;
            r_last_left    <= '0;
            r_last_right   <= '0;
            r_have_ref     <= 1'b0;
            r_moved        <= 1'b0;
            r_acc_x        <= '0;
            r_acc_z        <= '0;
            r_acc_dist     <= '0;
            r_acc_heading  <= '0;
            r_iter         <= ITER_END;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LEFT_STEP:    r_left_step    <= i_cfg_data[STEP_W-1:0];
                    CFG_RIGHT_STEP:   r_right_step   <= i_cfg_data[STEP_W-1:0];
                    CFG_HEADING_GAIN: r_heading_gain <= i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end

            if (accept) begin
                r_last_left  <= i_left_count;
                r_last_right <= i_right_count;
                r_have_ref   <= 1'b1;
                r_moved      <= r_have_ref;
                // clear pose and distance before this item is integrated
                if (i_new_interval) begin
                    r_acc_x       <= '0;
                    r_acc_z       <= '0;
                    r_acc_dist    <= '0;
                    r_acc_heading <= '0;
                end
                if (r_have_ref) begin
                    r_iter <= '0;
                end
            end else if (emit) begin
                r_acc_x       <= n_acc_x;
                r_acc_z       <= n_acc_z;
                r_acc_dist    <= n_acc_dist;
                r_acc_heading <= n_acc_heading;
            end

            if (cordic_run) begin
                r_iter <= r_iter + 1'b1;
            end

            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // CORDIC datapath: load on accept, one micro-rotation per cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cx   <= CORDIC_K;
            r_cy   <= '0;
            r_cz   <= {2'b00, head_rot[29:0]} - 32'h2000_0000;
            r_quad <= head_rot[31:30];
        end else if (cordic_run) begin
            if (!r_cz[31]) begin
                r_cx <= r_cx - shx;
                r_cy <= r_cy + shy;
                r_cz <= r_cz - atan_turn(r_iter);
            end else begin
                r_cx <= r_cx + shx;
                r_cy <= r_cy - shy;
                r_cz <= r_cz + atan_turn(r_iter);
            end
        end
    end

    // output payload, held until taken
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_x       <= n_acc_x;
            r_out_z       <= n_acc_z;
            r_out_heading <= n_acc_heading;
            r_out_dist    <= n_acc_dist;
            r_out_moved   <= r_moved;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pos_x     = r_out_x;
    assign o_pos_z     = r_out_z;
    assign o_heading   = r_out_heading;
    assign o_travelled = r_out_dist;
    assign o_moved     = r_out_moved;

    a_first_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !r_have_ref) |=> (r_state == S_DONE && !r_moved))
        else $error("first item did not skip integration");

    a_cordic_before_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIST && n_state == S_MID) |-> (r_iter == ITER_END))
        else $error("sine and cosine used before rotation finished");

    a_mults_before_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && n_state == S_DONE) |-> (done_sin && done_cos && done_turn))
        else $error("accumulate started before products finished");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_DONE))
        else $error("result shown without finishing an item");

endmodule

@@ hw/rtl/ddo_serial_mul.sv @@
`timescale 1ns / 1ps
// Bit-serial signed shift-add multiplier: one multiplier bit per cycle while run is asserted, LSB first.
// Depends on ddo_pkg (t_mul_ctrl).
module ddo_serial_mul #(
    parameter int A_W = 32,
    parameter int B_W = 33
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ddo_pkg::t_mul_ctrl    i_ctl,
    input  logic [A_W-1:0]        i_a,
    input  logic [B_W-1:0]        i_b,
    output logic [A_W+B_W-1:0]    o_p,
    output logic                  o_done
);
    import ddo_pkg::*;

    localparam int CNT_BITS = $clog2(B_W + 1);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(B_W - 1);
    localparam logic [CNT_BITS-1:0] CNT_DONE = CNT_BITS'(B_W);

    logic [A_W-1:0]       r_a;
    logic [A_W+B_W-1:0]   r_p;
    logic [A_W+B_W-1:0]   n_p;
    logic [CNT_BITS-1:0]  r_cnt;
    logic [A_W:0]         hi_ext;
    logic [A_W:0]         addend;
    logic [A_W:0]         sum;

    always_comb begin
        hi_ext = {r_p[A_W+B_W-1], r_p[A_W+B_W-1:B_W]};
        addend = r_p[0] ? {r_a[A_W-1], r_a} : '0;
        // the multiplier's top bit carries negative weight
        if (r_cnt == CNT_LAST) begin
            sum = hi_ext - addend;
        end else begin
            sum = hi_ext + addend;
        end
        n_p = {sum, r_p[B_W-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CNT_DONE;
        end else if (i_ctl.load) begin
            r_cnt <= '0;
        end else if (i_ctl.run && (r_cnt != CNT_DONE)) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a <= i_a;
            r_p <= {{A_W{1'b0}}, i_b};
        end else if (i_ctl.run && (r_cnt != CNT_DONE)) begin
            r_p <= n_p;
        end
    end

    assign o_p    = r_p;
    assign o_done = (r_cnt == CNT_DONE);

endmodule

@@ dv/pose_checker.sv @@
`timescale 1ns / 1ps
// Pose checker for the differential-drive odometry unit: watches the config port and
// both item channels, predicts every result and compares it field by field.
// Depends on ddo_pkg for widths and register indexes.
module pose_checker #(
    parameter int TRIG_FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ddo_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ddo_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic [ddo_pkg::CNT_W-1:0]          i_left_count,
    input  logic [ddo_pkg::CNT_W-1:0]          i_right_count,
    input  logic                               i_new_interval,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic signed [ddo_pkg::ACC_W-1:0]   i_pos_x,
    input  logic signed [ddo_pkg::ACC_W-1:0]   i_pos_z,
    input  logic [ddo_pkg::HEAD_W-1:0]         i_heading,
    input  logic signed [ddo_pkg::ACC_W-1:0]   i_travelled,
    input  logic                               i_moved,
    output int                                 o_mismatches,
    output int                                 o_pending,
    output int                                 o_checked,
    output int                                 o_moved_seen
);
    import ddo_pkg::*;

    typedef struct packed {
        logic signed [ACC_W-1:0] pos_x;
        logic signed [ACC_W-1:0] pos_z;
        logic [HEAD_W-1:0]       heading;
        logic signed [ACC_W-1:0] travelled;
        logic                    moved;
    } pose_t;

    localparam int     STEP_SCALE_BITS = 16;
    localparam int     ROT_STEPS       = 28;
    localparam int     PRINT_CAP       = 40;
    localparam longint ROT_GAIN_Q30    = 64'sd652032874;
    localparam longint ACC_MAX         = 64'sh7FFF_FFFF_FFFF;
    localparam longint ACC_MIN         = -64'sh8000_0000_0000;
    localparam longint PRODUCT_CLAMP   = 64'sh4_0000_0000_0000;

    // arctangent of 2^-i in 2^-32 turn
    longint rot_angle [ROT_STEPS] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
        64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
        64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
        64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005
    };

    // configuration copy
    logic [STEP_W-1:0] left_step_q;
    logic [STEP_W-1:0] right_step_q;
    logic [GAIN_W-1:0] gain_q;

    // integrator copy
    logic [CNT_W-1:0]  ref_left;
    logic [CNT_W-1:0]  ref_right;
    bit                has_ref;
    longint            pose_x;
    longint            pose_z;
    longint            dist_sum;
    logic [HEAD_W-1:0] head;

    pose_t expected_poses[$];
    pose_t want_pose;
    int    mismatch_count;
    int    checked_count;
    int    moved_count;

    function automatic longint wheel_travel(input logic [CNT_W-1:0] now_cnt,
                                            input logic [CNT_W-1:0] prev_cnt,
                                            input logic [STEP_W-1:0] step);
        logic signed [CNT_W-1:0] pulses;
        longint raw;
        pulses = now_cnt - prev_cnt;
        raw = longint'(pulses) * longint'(step);
        return raw >>> STEP_SCALE_BITS;
    endfunction

    // sin and cos of a heading, TRIG_FRAC_BITS fraction bits
    function automatic void heading_trig(input logic [HEAD_W-1:0] angle,
                                         output longint sn, output longint cs);
        logic [31:0] t;
        longint x, y, z, dx, dy, c, s;
        int i;
        t = angle + 32'h2000_0000;
        z = longint'(t[29:0]) - 64'sh2000_0000;
        x = ROT_GAIN_Q30;
        y = 0;
        for (i = 0; i < ROT_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - rot_angle[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + rot_angle[i];
            end
        end
        c = (x + (64'sd1 <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
        s = (y + (64'sd1 <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
        // odd quadrant swaps the pair, upper half negates it
        if (t[30]) begin
            cs = -s;
            sn = c;
        end else begin
            cs = c;
            sn = s;
        end
        if (t[31]) begin
            cs = -cs;
            sn = -sn;
        end
    endfunction

    // floor(a * t / 2^TRIG_FRAC_BITS), held within +-2^50
    function automatic longint scaled_floor(input longint a, input longint t);
        logic signed [127:0] p;
        p = a;
        p = p * t;
        p = p >>> TRIG_FRAC_BITS;
        if (p > PRODUCT_CLAMP) return PRODUCT_CLAMP;
        if (p < -PRODUCT_CLAMP) return -PRODUCT_CLAMP;
        return p[63:0];
    endfunction

    function automatic longint clamp_acc(input longint v);
        if (v > ACC_MAX) return ACC_MAX;
        if (v < ACC_MIN) return ACC_MIN;
        return v;
    endfunction

    function automatic pose_t predict_pose(input logic [CNT_W-1:0] lc,
                                           input logic [CNT_W-1:0] rc, input logic ni);
        pose_t r;
        longint dl, dr, mean, sn, cs;
        logic [63:0] turn;
        if (ni) begin
            pose_x = 0;
            pose_z = 0;
            dist_sum = 0;
            head = '0;
        end
        r.moved = has_ref;
        if (has_ref) begin
            dl = wheel_travel(lc, ref_left, left_step_q);
            dr = wheel_travel(rc, ref_right, right_step_q);
            mean = (dl + dr) >>> 1;
            turn = (dr - dl) * longint'(gain_q);
            // position uses the heading held before this turn
            heading_trig(head, sn, cs);
            pose_x = clamp_acc(pose_x - scaled_floor(mean, sn));
            pose_z = clamp_acc(pose_z - scaled_floor(mean, cs));
            dist_sum = clamp_acc(dist_sum + mean);
            head = head + turn[63:32];
        end
        ref_left = lc;
        ref_right = rc;
        has_ref = 1'b1;
        r.pos_x = pose_x[ACC_W-1:0];
        r.pos_z = pose_z[ACC_W-1:0];
        r.heading = head;
        r.travelled = dist_sum[ACC_W-1:0];
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) begin
            $display("mismatch at result %0d: %s got %h want %h", checked_count, what, got, want);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            left_step_q = '0;
            right_step_q = '0;
            gain_q = '0;
            ref_left = '0;
            ref_right = '0;
            has_ref = 1'b0;
            pose_x = 0;
            pose_z = 0;
            dist_sum = 0;
            head = '0;
            expected_poses.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LEFT_STEP:    left_step_q = i_cfg_data[STEP_W-1:0];
                    CFG_RIGHT_STEP:   right_step_q = i_cfg_data[STEP_W-1:0];
                    CFG_HEADING_GAIN: gain_q = i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_poses.size() == 0) begin
                    flag_mismatch("result with nothing expected", 64'd0, 64'd0);
                end else begin
                    want_pose = expected_poses.pop_front();
                    if (i_pos_x !== want_pose.pos_x)
                        flag_mismatch("pos_x", {16'h0, i_pos_x}, {16'h0, want_pose.pos_x});
                    if (i_pos_z !== want_pose.pos_z)
                        flag_mismatch("pos_z", {16'h0, i_pos_z}, {16'h0, want_pose.pos_z});
                    if (i_heading !== want_pose.heading)
                        flag_mismatch("heading", {32'h0, i_heading}, {32'h0, want_pose.heading});
                    if (i_travelled !== want_pose.travelled)
                        flag_mismatch("travelled", {16'h0, i_travelled},
                                      {16'h0, want_pose.travelled});
                    if (i_moved !== want_pose.moved)
                        flag_mismatch("moved", {63'h0, i_moved}, {63'h0, want_pose.moved});
                    if (want_pose.moved) moved_count++;
                end
                checked_count++;
            end
            if (i_in_valid && i_in_ready) begin
                expected_poses.push_back(predict_pose(i_left_count, i_right_count,
                                                      i_new_interval));
            end
        end
        o_pending <= expected_poses.size();
        o_mismatches <= mismatch_count;
        o_checked <= checked_count;
        o_moved_seen <= moved_count;
    end

    initial begin
        mismatch_count = 0;
        checked_count = 0;
        moved_count = 0;
        o_pending = 0;
        o_mismatches = 0;
        o_checked = 0;
        o_moved_seen = 0;
    end

endmodule

@@ dv/tb_differential_drive_odometry_unit.sv @@
`timescale 1ns / 1ps
// Testbench top for the differential-drive odometry unit: drives directed and random
// encoder samples under several register settings and gives the verdict.
// Depends on ddo_pkg, differential_drive_odometry_unit and pose_checker.
module tb_differential_drive_odometry_unit;
    import ddo_pkg::*;

    localparam int TRIG_FRAC_BITS = 16;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 204;
    localparam int IDLE_MARGIN    = 80;
    localparam int END_MARGIN     = 200;
    localparam int LONG_HOLD      = 600;
    localparam int RUN_LIMIT_NS   = 6_000_000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef enum int { RX_FREE, RX_HALF, RX_SPARSE } rx_mode_e;
    typedef enum int { STYLE_TYPICAL, STYLE_WILD, STYLE_ZERO, STYLE_MAX, STYLE_LOPSIDED }
        cfg_style_e;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_idx = '0;
    logic [CFG_W-1:0]          i_cfg_data = '0;
    logic                      i_valid = 1'b0;
    logic                      o_ready;
    logic [CNT_W-1:0]          i_left_count = '0;
    logic [CNT_W-1:0]          i_right_count = '0;
    logic                      i_new_interval = 1'b0;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic signed [ACC_W-1:0]   o_pos_x;
    logic signed [ACC_W-1:0]   o_pos_z;
    logic [HEAD_W-1:0]         o_heading;
    logic signed [ACC_W-1:0]   o_travelled;
    logic                      o_moved;

    int mismatches;
    int pending;
    int checked;
    int moved_seen;

    bit               hold_request = 1'b0;
    logic [CNT_W-1:0] cur_l = '0;
    logic [CNT_W-1:0] cur_r = '0;
    int               items_sent = 0;
    int               settings_count = 0;
    int               burst_left = 0;

    differential_drive_odometry_unit #(
        .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_left_count   (i_left_count),
        .i_right_count  (i_right_count),
        .i_new_interval (i_new_interval),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pos_x        (o_pos_x),
        .o_pos_z        (o_pos_z),
        .o_heading      (o_heading),
        .o_travelled    (o_travelled),
        .o_moved        (o_moved)
    );

    pose_checker #(
        .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
    ) u_pose_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_left_count   (i_left_count),
        .i_right_count  (i_right_count),
        .i_new_interval (i_new_interval),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_pos_x        (o_pos_x),
        .i_pos_z        (o_pos_z),
        .i_heading      (o_heading),
        .i_travelled    (o_travelled),
        .i_moved        (o_moved),
        .o_mismatches   (mismatches),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_moved_seen   (moved_seen)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end

    // result side: stall pattern of its own, plus a long hold on request
    initial begin : rx_pattern
        rx_mode_e mode;
        int seg;
        forever begin
            mode = rx_mode_e'($urandom_range(2, 0));
            seg = $urandom_range(300, 20);
            repeat (seg) begin
                @(posedge i_clk);
                if (hold_request) begin
                    i_ready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge i_clk);
                    hold_request = 1'b0;
                end
                case (mode)
                    RX_FREE: i_ready <= 1'b1;
                    RX_HALF: i_ready <= $urandom_range(1, 0);
                    default: i_ready <= ($urandom_range(7, 0) == 0);
                endcase
            end
        end
    end

    // offer one sample and hold it until accepted
    task automatic offer_item(input logic [CNT_W-1:0] lc, input logic [CNT_W-1:0] rc,
                              input logic ni);
        i_valid <= 1'b1;
        i_left_count <= lc;
        i_right_count <= rc;
        i_new_interval <= ni;
        cur_l = lc;
        cur_r = rc;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_valid <= 1'b0;
            if ($urandom_range(1, 0)) repeat ($urandom_range(8, 1)) @(posedge i_clk);
            else repeat ($urandom_range(100, 1)) @(posedge i_clk);
            burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 20)
                                                     : $urandom_range(8, 0);
        end
    endtask

    // stop offering and wait until every result is out
    task automatic drain_block();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (IDLE_MARGIN) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_config(input logic [STEP_W-1:0] ls, input logic [STEP_W-1:0] rs,
                               input logic [GAIN_W-1:0] g);
        write_cfg(CFG_LEFT_STEP, {8'h0, ls});
        write_cfg(CFG_RIGHT_STEP, {8'h0, rs});
        write_cfg(CFG_HEADING_GAIN, g);
        settings_count++;
    endtask

    function automatic logic [CNT_W-1:0] pick_extreme();
        case ($urandom_range(4, 0))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h8000_0001;
            3: return 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
        endcase
    endfunction

    initial begin : stimulus
        cfg_style_e style;
        logic [CNT_W-1:0] delta_l, delta_r;
        logic [STEP_W-1:0] ls, rs;
        logic [GAIN_W-1:0] g;
        int phase, k, pick;
        logic ni;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // registers still zero: first sample only sets the reference, then no motion
        offer_item(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
        offer_item(32'h1234_5678, 32'h8000_0000, 1'b0);
        drain_block();

        load_config(32'h0006_8DB9, 32'h0006_8DB9, 40'h12_3456_789A);
        offer_item(cur_l + 32'd1000, cur_r + 32'd1000, 1'b0);
        offer_item(cur_l + 32'd5000, cur_r, 1'b0);
        offer_item(cur_l, cur_r - 32'd3000, 1'b0);
        offer_item(32'hFFFF_FF00, 32'hFFFF_FF80, 1'b0);
        // wrap through zero
        offer_item(cur_l + 32'h200, cur_r + 32'h100, 1'b0);
        offer_item(cur_l + 32'd7, cur_r + 32'd9, 1'b1);
        offer_item(cur_l, cur_r, 1'b0);
        // jumps of half the count range or more read as reverse motion
        offer_item(cur_l + 32'h8000_0000, cur_r + 32'h8000_0001, 1'b0);
        offer_item(cur_l + 32'h7FFF_FFFF, cur_r - 32'h7FFF_FFFF, 1'b0);
        drain_block();

        // full-scale registers drive the accumulators into their limits
        load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
        write_cfg(CFG_UNUSED_IDX, '0);
        repeat (6) offer_item(cur_l + 32'h7FFF_FFFF, cur_r + 32'h7FFF_FFFF, 1'b0);
        repeat (2) offer_item(cur_l + 32'h7FFF_FFFF, cur_r + 32'h1000_0000, 1'b0);
        repeat (3) offer_item(cur_l + 32'h8000_0000, cur_r + 32'h8000_0000, 1'b0);
        drain_block();

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase < 4) style = cfg_style_e'(phase);
            else style = cfg_style_e'($urandom_range(4, 0));
            case (style)
                STYLE_TYPICAL: begin
                    ls = $urandom_range(32'h0010_0000, 32'h100);
                    rs = $urandom_range(32'h0010_0000, 32'h100);
                    g = {4'h0, 4'($urandom()), 32'($urandom())};
                end
                STYLE_WILD: begin
                    ls = $urandom();
                    rs = $urandom();
                    g = {8'($urandom()), 32'($urandom())};
                end
                STYLE_ZERO: begin
                    ls = '0;
                    rs = '0;
                    g = '0;
                end
                STYLE_MAX: begin
                    ls = '1;
                    rs = '1;
                    g = '1;
                end
                default: begin
                    ls = '1;
                    rs = $urandom_range(1000, 0);
                    g = {8'($urandom()), 32'($urandom())};
                end
            endcase
            load_config(ls, rs, g);

            for (k = 0; k < PHASE_ITEMS; k++) begin
                // long result stall while samples keep coming
                if ((phase == 1 || phase == 5) && k == 30) hold_request = 1'b1;
                pick = $urandom_range(99, 0);
                ni = ($urandom_range(24, 0) == 0);
                if (pick < 70) begin
                    delta_l = $urandom_range(4000, 0) - 2000;
                    delta_r = delta_l + $urandom_range(200, 0) - 100;
                end else if (pick < 84) begin
                    delta_l = $urandom();
                    delta_r = $urandom();
                end else if (pick < 92) begin
                    delta_l = pick_extreme();
                    delta_r = pick_extreme();
                end else begin
                    delta_l = $urandom_range(32'h00FF_FFFF, 0);
                    delta_r = $urandom_range(32'h00FF_FFFF, 0);
                    if ($urandom_range(1, 0)) delta_l = -delta_l;
                    if ($urandom_range(1, 0)) delta_r = -delta_r;
                end
                offer_item(cur_l + delta_l, cur_r + delta_r, ni);
                pace_sender();
            end
            drain_block();
        end

        repeat (END_MARGIN) @(posedge i_clk);
        $display("Covered %0d samples under %0d register settings, %0d results compared (%0d moving).",
                 items_sent, settings_count, checked, moved_seen);
        $display("Included count wraps, saturation, new intervals and a long output stall.");
        if (mismatches == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/ddo_pkg.sv
hw/rtl/ddo_serial_mul.sv
hw/rtl/differential_drive_odometry_unit.sv
dv/pose_checker.sv
dv/tb_differential_drive_odometry_unit.sv
